// ===== rtl/rne_pkg.sv =====
`timescale 1ns / 1ps

package rne_pkg;

  localparam int NumWidth      = 13;
  localparam int CharWidth     = 7;
  localparam int RestWidth     = NumWidth - 1;
  localparam int StepCount     = 13;
  localparam int StepWidth     = 4;
  localparam int IdxWidth      = 5;
  localparam int ResultLimit   = 19;
  localparam int MaxCharsDef   = 19;
  localparam int NegLen        = 19;
  localparam int ZeroLen       = 3;

  localparam logic [8*NegLen-1:0]  TextNeg  = "Et cecidit in finem";
  localparam logic [8*ZeroLen-1:0] TextZero = "Nil";

  localparam logic [CharWidth-1:0] NoChar = 7'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEXT,
    ST_SCAN,
    ST_PAIR
  } state_t;

  typedef struct packed {
    logic                 valid;
    logic [CharWidth-1:0] character;
    logic                 last;
  } emit_t;

  function automatic logic [RestWidth-1:0] step_value(input logic [StepWidth-1:0] k);
    logic [RestWidth-1:0] v;
    case (k)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  function automatic logic [CharWidth-1:0] step_first(input logic [StepWidth-1:0] k);
    logic [7:0] c;
    case (k)
      4'd0:    c = "M";
      4'd1:    c = "C";
      4'd2:    c = "D";
      4'd3:    c = "C";
      4'd4:    c = "C";
      4'd5:    c = "X";
      4'd6:    c = "L";
      4'd7:    c = "X";
      4'd8:    c = "X";
      4'd9:    c = "I";
      4'd10:   c = "V";
      default: c = "I";
    endcase
    return c[CharWidth-1:0];
  endfunction

  function automatic logic [CharWidth-1:0] step_second(input logic [StepWidth-1:0] k);
    logic [7:0] c;
    case (k)
      4'd1:    c = "M";
      4'd3:    c = "D";
      4'd5:    c = "C";
      4'd7:    c = "L";
      4'd9:    c = "X";
      4'd11:   c = "V";
      default: c = 8'd0;
    endcase
    return c[CharWidth-1:0];
  endfunction

  function automatic logic [CharWidth-1:0] text_char(input logic neg,
                                                     input logic [IdxWidth-1:0] idx);
    logic [7:0] c;
    c = 8'd0;
    if (neg) begin
      if (int'(idx) < NegLen) begin
        c = TextNeg[8*(NegLen-1-int'(idx)) +: 8];
      end
    end else begin
      if (int'(idx) < ZeroLen) begin
        c = TextZero[8*(ZeroLen-1-int'(idx)) +: 8];
      end
    end
    return c[CharWidth-1:0];
  endfunction

endpackage

// ===== rtl/rne_if.sv =====
`timescale 1ns / 1ps

interface rne_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [rne_pkg::NumWidth-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface rne_out_if;
  logic                            valid;
  logic                            ready;
  logic [rne_pkg::CharWidth-1:0]   character;
  logic                            last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

// ===== rtl/rne_core.sv =====
`timescale 1ns / 1ps

module rne_core #(
  parameter int MAX_CHARS = rne_pkg::MaxCharsDef
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [rne_pkg::NumWidth-1:0] number,
  input  logic                               can_emit,
  output logic                               idle,
  output rne_pkg::emit_t                     emit
);

  localparam int Cap = (MAX_CHARS > rne_pkg::ResultLimit) ? rne_pkg::ResultLimit :
                       ((MAX_CHARS < 1) ? 1 : MAX_CHARS);

  rne_pkg::state_t                   state, state_next;
  logic [rne_pkg::RestWidth-1:0]     rest, rest_next;
  logic [rne_pkg::StepWidth-1:0]     k, k_next;
  logic [rne_pkg::IdxWidth-1:0]      idx, idx_next;
  logic                              neg, neg_next;

  logic [rne_pkg::RestWidth:0]       diff;
  logic                              borrow;
  logic                              diff_zero;
  logic [rne_pkg::CharWidth-1:0]     second;
  logic                              text_end;

  // The shared subtractor tests and takes away one step value per cycle unless the output stalls.
  assign diff      = {1'b0, rest} - {1'b0, rne_pkg::step_value(k)};
  assign borrow    = diff[rne_pkg::RestWidth];
  assign diff_zero = (diff == '0);
  assign second    = rne_pkg::step_second(k);
  assign text_end  = (idx == (neg ? rne_pkg::IdxWidth'(rne_pkg::NegLen - 1)
                                  : rne_pkg::IdxWidth'(rne_pkg::ZeroLen - 1))) ||
                     (idx == rne_pkg::IdxWidth'(Cap - 1));

  assign idle = (state == rne_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rne_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
    rest <= rest_next;
    k    <= k_next;
    idx  <= idx_next;
    neg  <= neg_next;
  end

  always_comb begin
    state_next     = state;
    rest_next      = rest;
    k_next         = k;
    idx_next       = idx;
    neg_next       = neg;
    emit.valid     = 1'b0;
    emit.character = rne_pkg::NoChar;
    emit.last      = 1'b0;
    case (state)
      rne_pkg::ST_IDLE: begin
        if (start) begin
          idx_next  = '0;
          k_next    = '0;
          rest_next = number[rne_pkg::RestWidth-1:0];
          neg_next  = number[rne_pkg::NumWidth-1];
          if (number[rne_pkg::NumWidth-1] || (number == '0)) begin
            state_next = rne_pkg::ST_TEXT;
          end else begin
            state_next = rne_pkg::ST_SCAN;
          end
        end
      end
      rne_pkg::ST_TEXT: begin
        if (can_emit) begin
          emit.valid     = 1'b1;
          emit.character = rne_pkg::text_char(neg, idx);
          emit.last      = text_end;
          idx_next       = idx + 1'b1;
          if (text_end) begin
            state_next = rne_pkg::ST_IDLE;
          end
        end
      end
      rne_pkg::ST_SCAN: begin
        if (borrow) begin
          k_next = k + 1'b1;
        end else if (can_emit) begin
          emit.valid     = 1'b1;
          emit.character = rne_pkg::step_first(k);
          emit.last      = diff_zero && (second == rne_pkg::NoChar);
          rest_next      = diff[rne_pkg::RestWidth-1:0];
          if (second != rne_pkg::NoChar) begin
            state_next = rne_pkg::ST_PAIR;
          end else if (diff_zero) begin
            state_next = rne_pkg::ST_IDLE;
          end
        end
      end
      rne_pkg::ST_PAIR: begin
        if (can_emit) begin
          emit.valid     = 1'b1;
          emit.character = second;
          emit.last      = (rest == '0);
          state_next     = (rest == '0) ? rne_pkg::ST_IDLE : rne_pkg::ST_SCAN;
        end
      end
      default: begin
        state_next = rne_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/roman_numeral_encoder.sv =====
`timescale 1ns / 1ps

// Channel   Role     Payload
// item      sink     number (13-bit signed)
// result    source   character (7-bit ASCII), last
//
// A number is loaded first; the sequencer then emits its characters in turn,
// passing over step values skipped by the shared subtractor (at most 12).
// A character held in the output register does not stop the sequencer from
// preparing the next one; a stalled result holds the sequencer until taken.
// Reset is synchronous and returns the block to idle with no result pending.

module roman_numeral_encoder #(
  parameter int MAX_CHARS = rne_pkg::MaxCharsDef
) (
  input logic        clk,
  input logic        rst,
  rne_in_if.sink     item,
  rne_out_if.source  result
);

  logic           idle;
  logic           can_emit;
  rne_pkg::emit_t emit;

  logic                          out_valid;
  logic [rne_pkg::CharWidth-1:0] out_character;
  logic                          out_last;

  assign item.ready = idle;
  assign can_emit   = !out_valid || result.ready;

  rne_core #(
    .MAX_CHARS (MAX_CHARS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (item.valid && idle),
    .number   (item.number),
    .can_emit (can_emit),
    .idle     (idle),
    .emit     (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (emit.valid) begin
      out_character <= emit.character;
      out_last      <= emit.last;
    end
  end

  assign result.valid     = out_valid;
  assign result.character = out_character;
  assign result.last      = out_last;

endmodule

// ===== rtl/rne_check.sv =====
`timescale 1ns / 1ps

module rne_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rne_pkg::CharWidth-1:0] character,
  input logic                          last
);

  // Once a number is taken, input ready drops straight after the transfer.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready straight after an input transfer");

  // A character waiting while new input is allowed must close its text.
  a_waiting_is_last: assert property (@(posedge clk) disable iff (rst)
    (in_ready && out_valid) |-> last)
    else $error("pending character is not the last while input is ready");

  // Every character emitted is printable.
  a_printable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character >= 7'd32))
    else $error("non-printable character emitted");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(character) && $stable(last)))
    else $error("stalled result changed");

endmodule

bind roman_numeral_encoder rne_check u_rne_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .character (result.character),
  .last      (result.last)
);
